// File: rtl/gdbp_pkg.sv
package gdbp_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int QUEUE_DEPTH = 2;

    localparam int PIXEL_W = 8;
    localparam int WIDTH_REG_W = 11;
    localparam int HEIGHT_REG_W = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic RESET_DITHER_MODE = 1'b1;
    localparam logic [7:0] RESET_THRESHOLD = 8'd128;
    localparam logic [WIDTH_REG_W-1:0] RESET_IMAGE_WIDTH = 11'd576;
    localparam logic [HEIGHT_REG_W-1:0] RESET_IMAGE_HEIGHT = 16'd1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DITHER_MODE  = 2'd0,
        CFG_THRESHOLD    = 2'd1,
        CFG_IMAGE_WIDTH  = 2'd2,
        CFG_IMAGE_HEIGHT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                    dither_mode;
        logic [7:0]              threshold;
        logic [WIDTH_REG_W-1:0]  image_width;
        logic [HEIGHT_REG_W-1:0] image_height;
    } cfg_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        logic               last_row;
        logic               first_row;
    } item_t;

    // signed product / 16, truncated toward zero
    function automatic logic signed [8:0] div16(input logic signed [12:0] p);
        logic signed [12:0] biased;
        biased = p + ((p < 13'sd0) ? 13'sd15 : 13'sd0);
        return 9'(biased >>> 4);
    endfunction

endpackage

// File: rtl/gray_dither_bit_packer_unit.sv
// channel   direction  handshake                  payload
// s_        in         s_tvalid / s_tready        s_tdata[7:0] pixel
// m_        out        m_tvalid / m_tready        m_tdata packed_byte, m_tlast row_end,
//                                                  m_tuser image_end
// cfg_      in         cfg_valid / cfg_ready      cfg_addr register index, cfg_data value
//
// One pixel per cycle sustained while the output does not stall; after its last pixel
// is taken, a byte passes through queue, store read, diffusion and output register.
// The diffusion loop (add, clamp, compare, 7/16 carry) is combinational and closes through rc_reg.
// After reset all MAX_WIDTH entries of the error row store are cleared; s_tready stays
// low meanwhile, cfg writes are taken.
// A stalled output holds the diffusion stage; the two-entry queue takes pixels
// until it holds two, then s_tready drops.
module gray_dither_bit_packer_unit #(
    parameter int MAX_WIDTH = gdbp_pkg::MAX_WIDTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] pixel
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] packed_byte
    output logic                             m_tlast,
    output logic                             m_tuser,   // [0] image_end
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gdbp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gdbp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ITEM_W = $bits(gdbp_pkg::item_t);
    localparam int Q_W = ITEM_W + COL_W;

    gdbp_pkg::cfg_t  cfg;
    gdbp_pkg::item_t push_item, pop_item;
    logic [COL_W-1:0] push_col, pop_col;
    logic [Q_W-1:0] q_din, q_dout;
    logic q_push, q_pop, q_full, q_not_empty, clearing;

    assign cfg_ready = 1'b1;

    gdbp_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .clearing  (clearing),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item),
        .q_col     (push_col)
    );

    assign q_din = {push_col, push_item};

    gdbp_queue #(
        .DATA_W (Q_W),
        .DEPTH  (gdbp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .dout      (q_dout)
    );

    assign pop_item = gdbp_pkg::item_t'(q_dout[ITEM_W-1:0]);
    assign pop_col = q_dout[Q_W-1:ITEM_W];

    gdbp_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_not_empty),
        .q_item   (pop_item),
        .q_col    (pop_col),
        .q_pop    (q_pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/gdbp_front.sv
module gdbp_front #(
    parameter int MAX_WIDTH = gdbp_pkg::MAX_WIDTH_DEF,
    parameter int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [gdbp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [gdbp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gdbp_pkg::cfg_t                   cfg,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [gdbp_pkg::PIXEL_W-1:0]     s_tdata,
    input  logic                             clearing,
    input  logic                             q_full,
    output logic                             q_push,
    output gdbp_pkg::item_t                  q_item,
    output logic [COL_W-1:0]                 q_col
);

    localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > gdbp_pkg::WIDTH_REG_W) ?
                            $clog2(MAX_WIDTH + 1) : gdbp_pkg::WIDTH_REG_W;
    localparam int RCMP_W = gdbp_pkg::HEIGHT_REG_W + 1;

    gdbp_pkg::cfg_t cfg_reg;
    logic [COL_W-1:0] col_reg, col_next;
    logic [gdbp_pkg::HEIGHT_REG_W-1:0] row_reg, row_next;

    logic [WCMP_W-1:0] width_raw, width_eff, col_plus;
    logic [RCMP_W-1:0] height_eff, row_plus;
    logic row_end, last_row;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dither_mode  <= gdbp_pkg::RESET_DITHER_MODE;
            cfg_reg.threshold    <= gdbp_pkg::RESET_THRESHOLD;
            cfg_reg.image_width  <= gdbp_pkg::RESET_IMAGE_WIDTH;
            cfg_reg.image_height <= gdbp_pkg::RESET_IMAGE_HEIGHT;
        end else if (cfg_valid) begin
            unique case (gdbp_pkg::cfg_index_t'(cfg_addr))
                gdbp_pkg::CFG_DITHER_MODE:  cfg_reg.dither_mode <= cfg_data[0];
                gdbp_pkg::CFG_THRESHOLD:    cfg_reg.threshold <= cfg_data[7:0];
                gdbp_pkg::CFG_IMAGE_WIDTH:
                    cfg_reg.image_width <= cfg_data[gdbp_pkg::WIDTH_REG_W-1:0];
                gdbp_pkg::CFG_IMAGE_HEIGHT:
                    cfg_reg.image_height <= cfg_data[gdbp_pkg::HEIGHT_REG_W-1:0];
                default: cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

    always_comb begin
        width_raw = WCMP_W'(cfg_reg.image_width);
        if (width_raw == '0) begin
            width_eff = WCMP_W'(1);
        end else if (width_raw > WCMP_W'(MAX_WIDTH)) begin
            width_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            width_eff = width_raw;
        end
        height_eff = (cfg_reg.image_height == '0) ? RCMP_W'(1) : RCMP_W'(cfg_reg.image_height);
        col_plus = WCMP_W'(col_reg) + WCMP_W'(1);
        row_plus = RCMP_W'(row_reg) + RCMP_W'(1);
        row_end = (col_plus >= width_eff);
        last_row = (row_plus >= height_eff);

        col_next = row_end ? '0 : col_plus[COL_W-1:0];
        if (!row_end) begin
            row_next = row_reg;
        end else if (last_row) begin
            row_next = '0;
        end else begin
            row_next = row_plus[gdbp_pkg::HEIGHT_REG_W-1:0];
        end
    end

    assign s_tready = !q_full && !clearing;
    assign q_push = s_tvalid && s_tready;

    always_comb begin
        q_item.pixel = s_tdata;
        q_item.row_end = row_end;
        q_item.last_row = last_row;
        q_item.first_row = (row_reg == '0);
        q_col = col_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (q_push) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: rtl/gdbp_queue.sv
module gdbp_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH = gdbp_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] din,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign dout = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !not_empty |-> !pop)
        else $error("queue pop while empty");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// File: rtl/gdbp_back.sv
module gdbp_back #(
    parameter int MAX_WIDTH = gdbp_pkg::MAX_WIDTH_DEF,
    parameter int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  gdbp_pkg::cfg_t          cfg,
    input  logic                    q_valid,
    input  gdbp_pkg::item_t         q_item,
    input  logic [COL_W-1:0]        q_col,
    output logic                    q_pop,
    output logic                    clearing,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [7:0]              m_tdata,
    output logic                    m_tlast,
    output logic                    m_tuser
);

    // error row store
    logic signed [8:0] err_mem [MAX_WIDTH];
    logic signed [8:0] mem_rd_reg;

    logic              clr_active_reg;
    logic [COL_W-1:0]  clr_addr_reg;

    // read stage
    logic              a_valid_reg, a_valid_next;
    gdbp_pkg::item_t   a_item_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic              a_fwd_valid_reg;
    logic signed [8:0] a_fwd_data_reg;
    logic              a_load, fire;

    // diffusion state
    logic signed [7:0] rc_reg, rc_next;
    logic signed [7:0] bpl_reg, bpl_next;
    logic signed [4:0] bph_reg, bph_next;
    logic [7:0]        dot_shift_reg, dot_shift_next;
    logic [2:0]        dot_cnt_reg, dot_cnt_next;

    // deferred row-end write
    logic              def_valid_reg;
    logic [COL_W-1:0]  def_col_reg;
    logic signed [8:0] def_data_reg;
    logic              def_hit;

    // output register
    logic              m_valid_reg;
    logic [7:0]        m_byte_reg;
    logic              m_last_reg, m_user_reg;

    // datapath
    logic signed [8:0]  e_in, err, down, cmp_wdata;
    logic signed [10:0] v;
    logic [7:0]         vc, byte_out;
    logic               dot, emit;
    logic [3:0]         n;

    // write port
    logic              we, cmp_we;
    logic [COL_W-1:0]  waddr;
    logic signed [8:0] wdata;

    assign clearing = clr_active_reg;
    assign fire = a_valid_reg && (!m_valid_reg || m_tready);
    assign a_load = q_valid && (!a_valid_reg || fire);
    assign q_pop = a_load;
    assign a_valid_next = a_load ? 1'b1 : (fire ? 1'b0 : a_valid_reg);
    assign cmp_we = fire && (a_col_reg != '0);

    always_comb begin
        def_hit = def_valid_reg && (def_col_reg == a_col_reg);
        priority if (a_item_reg.first_row) begin
            e_in = 9'sd0;
        end else if (def_hit) begin
            e_in = def_data_reg;
        end else if (a_fwd_valid_reg) begin
            e_in = a_fwd_data_reg;
        end else begin
            e_in = mem_rd_reg;
        end
        v = 11'(signed'({3'b000, a_item_reg.pixel})) + 11'(e_in) + 11'(rc_reg);
        if (v < 11'sd0) begin
            vc = 8'd0;
        end else if (v > 11'sd255) begin
            vc = 8'd255;
        end else begin
            vc = v[7:0];
        end
        if (cfg.dither_mode) begin
            dot = (vc < cfg.threshold);
            err = dot ? signed'({1'b0, vc}) : signed'({1'b0, vc}) - 9'sd255;
        end else begin
            dot = (a_item_reg.pixel < cfg.threshold);
            err = 9'sd0;
        end

        rc_next = a_item_reg.row_end ? 8'sd0 : 8'(gdbp_pkg::div16(13'(err) * 13'sd7));
        down = a_item_reg.last_row ? 9'sd0 : err;
        cmp_wdata = 9'(bpl_reg) + gdbp_pkg::div16(13'(down) * 13'sd3);
        bpl_next = 8'(9'(bph_reg) + gdbp_pkg::div16(13'(down) * 13'sd5));
        bph_next = a_item_reg.row_end ? 5'sd0 : 5'(gdbp_pkg::div16(13'(down)));

        dot_shift_next = {dot_shift_reg[6:0], dot};
        n = 4'(dot_cnt_reg) + 4'd1;
        emit = (n == 4'd8) || a_item_reg.row_end;
        byte_out = dot_shift_next << (4'd8 - n);
        dot_cnt_next = emit ? 3'd0 : n[2:0];
    end

    always_comb begin
        if (clr_active_reg) begin
            we = 1'b1;
            waddr = clr_addr_reg;
            wdata = 9'sd0;
        end else if (def_valid_reg) begin
            we = 1'b1;
            waddr = def_col_reg;
            wdata = def_data_reg;
        end else begin
            we = cmp_we;
            waddr = a_col_reg - COL_W'(1);
            wdata = cmp_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            err_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            mem_rd_reg <= err_mem[q_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_active_reg) begin
            clr_addr_reg <= clr_addr_reg + COL_W'(1);
            if (clr_addr_reg == COL_W'(MAX_WIDTH - 1)) begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            a_fwd_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            if (a_load) begin
                a_fwd_valid_reg <= we && (waddr == q_col);
            end else if (a_valid_reg && we && (waddr == a_col_reg)) begin
                a_fwd_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_item_reg <= q_item;
            a_col_reg <= q_col;
            a_fwd_data_reg <= wdata;
        end else if (a_valid_reg && we && (waddr == a_col_reg)) begin
            a_fwd_data_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rc_reg <= '0;
            bpl_reg <= '0;
            bph_reg <= '0;
            dot_shift_reg <= '0;
            dot_cnt_reg <= '0;
            def_valid_reg <= 1'b0;
        end else begin
            def_valid_reg <= fire && a_item_reg.row_end;
            if (fire) begin
                rc_reg <= rc_next;
                bpl_reg <= a_item_reg.row_end ? 8'sd0 : bpl_next;
                bph_reg <= bph_next;
                dot_shift_reg <= emit ? 8'd0 : dot_shift_next;
                dot_cnt_reg <= dot_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && a_item_reg.row_end) begin
            def_col_reg <= a_col_reg;
            def_data_reg <= 9'(bpl_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (fire && emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && emit) begin
            m_byte_reg <= byte_out;
            m_last_reg <= a_item_reg.row_end;
            m_user_reg <= a_item_reg.row_end && a_item_reg.last_row;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_byte_reg;
    assign m_tlast = m_last_reg;
    assign m_tuser = m_user_reg;

`ifndef SYNTH
    a_write_port_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmp_we && (def_valid_reg || clr_active_reg)))
        else $error("error store write collision");
    a_no_load_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_active_reg |-> !a_load && !a_valid_reg)
        else $error("item taken during store clear");
    a_row_end_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && a_item_reg.row_end |=> rc_reg == 8'sd0 && bpl_reg == 8'sd0
            && bph_reg == 5'sd0 && dot_cnt_reg == 3'd0)
        else $error("carries not drained at row end");
    a_row_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && a_item_reg.row_end |=> m_valid_reg && m_last_reg)
        else $error("row end without byte");
`endif

endmodule

// File: tb/sv/gray_dither_bit_packer_unit_tb.sv
module gray_dither_bit_packer_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = gdbp_pkg::MAX_WIDTH_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [7:0] dots;
        logic       row_last;
        logic       image_last;
    } dot_byte_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [7:0]                      s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;
    logic                            m_tlast;
    logic                            m_tuser;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [gdbp_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [gdbp_pkg::CFG_DATA_W-1:0] cfg_data;

    // dither state mirrored from the block
    logic                              cfg_mode   = gdbp_pkg::RESET_DITHER_MODE;
    logic [7:0]                        cfg_thresh = gdbp_pkg::RESET_THRESHOLD;
    logic [gdbp_pkg::WIDTH_REG_W-1:0]  cfg_width  = gdbp_pkg::RESET_IMAGE_WIDTH;
    logic [gdbp_pkg::HEIGHT_REG_W-1:0] cfg_height = gdbp_pkg::RESET_IMAGE_HEIGHT;
    int                                err_row [MAX_W];
    int                                carry_right;
    int                                pend_left;
    int                                pend_here;
    int                                col_pos;
    int                                row_pos;
    logic [7:0]                        shift_reg;
    int                                dot_cnt;

    dot_byte_t expected_bytes[$];

    bit idle_en;
    int fail_cnt;
    int pixel_cnt;
    int byte_cnt;
    int cfg_cnt;
    int stall_cycles;
    int ramp_px;
    int rdy_hold;

    gray_dither_bit_packer_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void dither_pixel(input logic [7:0] px);
        int        w;
        int        h;
        int        x;
        int        e_in;
        int        v;
        int        err;
        int        down;
        int        n;
        bit        row_last;
        bit        final_row;
        bit        dot;
        dot_byte_t r;
        w = (cfg_width == 0) ? 1 : int'(cfg_width);
        if (w > MAX_W) begin
            w = MAX_W;
        end
        h = (cfg_height == 0) ? 1 : int'(cfg_height);
        x = col_pos;
        row_last = (x + 1 >= w);
        final_row = (row_pos + 1 >= h);
        e_in = (row_pos != 0 && x < MAX_W) ? err_row[x] : 0;

        if (cfg_mode) begin
            v = int'(px) + e_in + carry_right;
            if (v < 0) begin
                v = 0;
            end
            if (v > 255) begin
                v = 255;
            end
            dot = (v < int'(cfg_thresh));
            err = dot ? v : v - 255;
        end else begin
            dot = (int'(px) < int'(cfg_thresh));
            err = 0;
        end

        carry_right = row_last ? 0 : err * 7 / 16;
        down = final_row ? 0 : err;
        if (x > 0 && x - 1 < MAX_W) begin
            err_row[x - 1] = pend_left + down * 3 / 16;
        end
        pend_left = pend_here + down * 5 / 16;
        pend_here = row_last ? 0 : down / 16;
        if (row_last) begin
            if (x < MAX_W) begin
                err_row[x] = pend_left;
            end
            pend_left = 0;
            pend_here = 0;
        end

        shift_reg = {shift_reg[6:0], dot};
        n = dot_cnt + 1;
        if (row_last) begin
            col_pos = 0;
            row_pos = final_row ? 0 : (row_pos + 1) & 16'hFFFF;
        end else begin
            col_pos = x + 1;
        end

        if (n >= 8 || row_last) begin
            r.dots = shift_reg << (8 - n);
            r.row_last = row_last;
            r.image_last = row_last && final_row;
            expected_bytes.insert(expected_bytes.size(), r);
            shift_reg = '0;
            dot_cnt = 0;
        end else begin
            dot_cnt = n;
        end
    endfunction

    function automatic logic [7:0] pick_pixel(input int style);
        int t;
        case (style)
            0: t = $urandom_range(0, 255);
            1: begin
                case ($urandom_range(0, 3))
                    0: t = 0;
                    1: t = 255;
                    2: t = 1;
                    default: t = 254;
                endcase
            end
            2: t = int'(cfg_thresh) + int'($urandom_range(0, 16)) - 8;
            default: begin
                ramp_px = ramp_px + int'($urandom_range(0, 12)) - 6;
                t = ramp_px;
            end
        endcase
        if (t < 0) begin
            t = 0;
        end
        if (t > 255) begin
            t = 255;
        end
        ramp_px = t;
        return 8'(t);
    endfunction

    // entered and left at a falling edge; tvalid stays high for a back-to-back beat
    task automatic send_pixel(input logic [7:0] px);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= px;
        do @(posedge aclk); while (!s_tready);
        dither_pixel(px);
        pixel_cnt++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input gdbp_pkg::cfg_index_t idx,
                             input logic [gdbp_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            gdbp_pkg::CFG_DITHER_MODE:  cfg_mode = val[0];
            gdbp_pkg::CFG_THRESHOLD:    cfg_thresh = val[7:0];
            gdbp_pkg::CFG_IMAGE_WIDTH:  cfg_width = val[gdbp_pkg::WIDTH_REG_W-1:0];
            gdbp_pkg::CFG_IMAGE_HEIGHT: cfg_height = val[gdbp_pkg::HEIGHT_REG_W-1:0];
            default: ;
        endcase
        cfg_cnt++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // drain: partial bytes leave no beat, so let the pipeline settle afterwards
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic test_threshold_mode();
        wait_idle();
        write_reg(gdbp_pkg::CFG_DITHER_MODE, 16'd0);
        write_reg(gdbp_pkg::CFG_THRESHOLD, 16'd0);
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd0);
        write_reg(gdbp_pkg::CFG_IMAGE_HEIGHT, 16'd0);
        send_pixel(8'd0);
        send_pixel(8'd255);
        wait_idle();
        write_reg(gdbp_pkg::CFG_THRESHOLD, 16'd255);
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd2);
        write_reg(gdbp_pkg::CFG_IMAGE_HEIGHT, 16'd1);
        send_pixel(8'd254);
        send_pixel(8'd255);
    endtask

    task automatic test_diffusion_clamp();
        logic [7:0] pix [9] = '{8'd200, 8'd60, 8'd255, 8'd0, 8'd130, 8'd255,
                                8'd0, 8'd90, 8'd250};
        wait_idle();
        write_reg(gdbp_pkg::CFG_DITHER_MODE, 16'd1);
        write_reg(gdbp_pkg::CFG_THRESHOLD, 16'd128);
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd3);
        write_reg(gdbp_pkg::CFG_IMAGE_HEIGHT, 16'd3);
        foreach (pix[i]) begin
            send_pixel(pix[i]);
        end
    endtask

    task automatic test_geometry_mid_row();
        wait_idle();
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd2047);
        write_reg(gdbp_pkg::CFG_IMAGE_HEIGHT, 16'd65535);
        repeat (5) send_pixel(pick_pixel(0));
        wait_idle();
        write_reg(gdbp_pkg::CFG_DITHER_MODE, 16'd0);
        repeat (3) send_pixel(pick_pixel(2));
        wait_idle();
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd4);
        send_pixel(pick_pixel(0));
        wait_idle();
        write_reg(gdbp_pkg::CFG_DITHER_MODE, 16'd1);
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd3);
        write_reg(gdbp_pkg::CFG_IMAGE_HEIGHT, 16'd0);
        repeat (3) send_pixel(pick_pixel(1));
    endtask

    task automatic test_wide_row();
        wait_idle();
        write_reg(gdbp_pkg::CFG_THRESHOLD, 16'($urandom_range(64, 192)));
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'(MAX_W));
        write_reg(gdbp_pkg::CFG_IMAGE_HEIGHT, 16'd2);
        for (int i = 0; i < MAX_W; i++) begin
            send_pixel(pick_pixel((i / 128) % 4));
        end
        wait_idle();
        write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd16);
        repeat (16) send_pixel(pick_pixel(0));
    endtask

    task automatic test_random_images(input int n_items);
        int  start;
        int  cnt;
        int  we;
        int  he;
        int  style;
        int  hv;
        bit  first;
        start = pixel_cnt;
        first = 1'b1;
        while (pixel_cnt - start < n_items) begin
            wait_idle();
            idle_en = (pixel_cnt - start < n_items - 200) && ($urandom_range(0, 3) != 0);
            if (first || $urandom_range(0, 1)) begin
                write_reg(gdbp_pkg::CFG_DITHER_MODE, 16'($urandom_range(0, 3) != 0));
            end
            if (first || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0: write_reg(gdbp_pkg::CFG_THRESHOLD, 16'd0);
                    1: write_reg(gdbp_pkg::CFG_THRESHOLD, 16'd255);
                    default: write_reg(gdbp_pkg::CFG_THRESHOLD, 16'($urandom_range(0, 255)));
                endcase
            end
            if (first || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 19))
                    0: write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'd0);
                    1: write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'($urandom_range(25, 64)));
                    default: write_reg(gdbp_pkg::CFG_IMAGE_WIDTH, 16'($urandom_range(1, 16)));
                endcase
            end
            if (first || $urandom_range(0, 1)) begin
                case ($urandom_range(0, 9))
                    0: hv = 0;
                    1: hv = 65535;
                    default: hv = $urandom_range(1, 4);
                endcase
                write_reg(gdbp_pkg::CFG_IMAGE_HEIGHT, 16'(hv));
            end
            first = 1'b0;
            we = (cfg_width == 0) ? 1 : int'(cfg_width);
            he = (cfg_height == 0) ? 1 : int'(cfg_height);
            if (he > 3) begin
                he = 3;
            end
            if ($urandom_range(0, 7) == 0) begin
                cnt = $urandom_range(1, 40);
            end else begin
                cnt = we * he * $urandom_range(1, 2);
            end
            style = $urandom_range(0, 3);
            for (int i = 0; i < cnt; i++) begin
                send_pixel(pick_pixel(style));
            end
        end
    endtask

    initial begin
        m_tready = 1'b0;
        rdy_hold = 0;
        forever begin
            @(negedge aclk);
            if (rdy_hold > 0) begin
                rdy_hold--;
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                rdy_hold = $urandom_range(1, 10) - 1;
            end else begin
                m_tready <= 1'b1;
                rdy_hold = $urandom_range(1, 20) - 1;
            end
        end
    end

    always @(posedge aclk) begin
        dot_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            byte_cnt++;
            if (expected_bytes.size() == 0) begin
                $error("unexpected beat: packed_byte %02h row_end %0b image_end %0b",
                       m_tdata, m_tlast, m_tuser);
                fail_cnt++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.dots) begin
                    $error("packed_byte: expected %02h, got %02h", want.dots, m_tdata);
                    fail_cnt++;
                end
                if (m_tlast !== want.row_last) begin
                    $error("row_end: expected %0b, got %0b", want.row_last, m_tlast);
                    fail_cnt++;
                end
                if (m_tuser !== want.image_last) begin
                    $error("image_end: expected %0b, got %0b", want.image_last, m_tuser);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("gray_dither_bit_packer_unit: mismatch");
                $finish;
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = gdbp_pkg::CFG_DITHER_MODE;
        cfg_data = '0;
        idle_en = 1'b1;
        fail_cnt = 0;
        pixel_cnt = 0;
        byte_cnt = 0;
        cfg_cnt = 0;
        ramp_px = 128;
        carry_right = 0;
        pend_left = 0;
        pend_here = 0;
        col_pos = 0;
        row_pos = 0;
        shift_reg = '0;
        dot_cnt = 0;
        foreach (err_row[i]) begin
            err_row[i] = 0;
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_threshold_mode();
        test_diffusion_clamp();
        test_geometry_mid_row();
        test_wide_row();
        test_random_images(885);

        wait_idle();
        $display("Covered %0d pixels, %0d output bytes, %0d register writes", pixel_cnt,
                 byte_cnt, cfg_cnt);
        $display("Both dither modes, widths 0 to 2047, heights 0 to 65535, %0d mismatches",
                 fail_cnt);
        if (fail_cnt == 0) begin
            $display("gray_dither_bit_packer_unit: match");
        end else begin
            $display("gray_dither_bit_packer_unit: mismatch");
        end
        $finish;
    end

endmodule
